FILE: src/rgblpg_pkg.sv
// Package for the RGB light pattern generator: field widths, pattern
// modes, register indexes and reset constants. No dependencies.
`default_nettype none

package rgblpg_pkg;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned RATIO_W  = 9;
  localparam int unsigned SLEEP_W  = 16;
  localparam int unsigned TICK_W   = 17;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 8'd128;
  localparam logic [LEVEL_W-1:0] LEVEL_TOP   = 8'd255;
  localparam logic [SLEEP_W-1:0] SLEEP_RESET = 16'd100;
  localparam logic [RATIO_W-1:0] RATIO_ONE   = 9'd256;
  localparam logic [TICK_W-1:0]  TICK_MAX    = 17'h1FFFF;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF,
    MODE_ON,
    MODE_NOISE,
    MODE_FLICKER,
    MODE_FLASH,
    MODE_RAMP_UP,
    MODE_RAMP_DOWN
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_MODE,
    REG_RANGE_MIN,
    REG_RANGE_MAX,
    REG_SLEEP_MS,
    REG_RED_RATIO,
    REG_GREEN_RATIO,
    REG_BLUE_RATIO
  } cfg_reg_e;

endpackage

`default_nettype wire

FILE: src/rgblpg_if.sv
// Valid/ready channel interfaces for the pattern generator's input tick
// items and result items. Depends on rgblpg_pkg.
`default_nettype none

interface rgblpg_in_if;
  logic                               valid;
  logic                               ready;
  logic [rgblpg_pkg::SAMPLE_W-1:0]    random_sample;

  modport source (output valid, output random_sample, input ready);
  modport sink   (input valid, input random_sample, output ready);
endinterface

interface rgblpg_out_if;
  logic                               valid;
  logic                               ready;
  logic [rgblpg_pkg::LEVEL_W-1:0]     red_drive;
  logic [rgblpg_pkg::LEVEL_W-1:0]     green_drive;
  logic [rgblpg_pkg::LEVEL_W-1:0]     blue_drive;
  logic [rgblpg_pkg::LEVEL_W-1:0]     level_now;
  logic                               updated;

  modport source (output valid, output red_drive, output green_drive, output blue_drive,
                  output level_now, output updated, input ready);
  modport sink   (input valid, input red_drive, input green_drive, input blue_drive,
                  input level_now, input updated, output ready);
endinterface

`default_nettype wire

FILE: src/rgb_light_pattern_generator_unit.sv
// Top level of the RGB light pattern generator: config registers, tick
// counter, level update and color scaling. Depends on rgblpg_pkg, rgblpg_if.
`default_nettype none

// Each input item is one millisecond tick with a random byte. The block
// counts ticks; once the count exceeds sleep_ms it moves the brightness
// level by the selected pattern (off, on, noise, flicker, flash, ramp up,
// ramp down), clears the count, and rescales red/green/blue as
// (level * ratio) >> 8, saturated at 255. Between updates all drives hold.
// Every tick yields exactly one result item, with updated flagging ticks
// that moved the level. The datapath is three register stages (input
// sample, level/counter update, color scaling into the output register),
// so a tick's result moves through those registers in that order to the
// output, and one item is taken per cycle while the output is read.
// The whole pipe advances together: a result that waits at the output
// freezes every stage and holds the input off until it is taken.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i by the user
// only while the block is idle; it does not enforce this. Index 7 ignored.
// Reset: mode off, range 0..255, sleep 100, ratios 1.0, level 128, drives 0.
module rgb_light_pattern_generator_unit (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [rgblpg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [rgblpg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  rgblpg_in_if.sink                        item_in,
  rgblpg_out_if.source                     item_out
);
  import rgblpg_pkg::*;

  // configuration registers
  logic [MODE_W-1:0]  mode_q;
  logic [LEVEL_W-1:0] range_min_q;
  logic [LEVEL_W-1:0] range_max_q;
  logic [SLEEP_W-1:0] sleep_q;
  logic [RATIO_W-1:0] red_ratio_q;
  logic [RATIO_W-1:0] green_ratio_q;
  logic [RATIO_W-1:0] blue_ratio_q;

  // pipeline: A holds the sample, B the updated level, C is the output
  logic                advance;
  logic                a_valid_q;
  logic [SAMPLE_W-1:0] a_rnd_q;
  logic                b_valid_q;
  logic                b_upd_q;
  logic [LEVEL_W-1:0]  b_level_q;
  logic                c_valid_q;
  logic                c_upd_q;
  logic [LEVEL_W-1:0]  c_level_q;
  logic [LEVEL_W-1:0]  red_q;
  logic [LEVEL_W-1:0]  green_q;
  logic [LEVEL_W-1:0]  blue_q;

  // state
  logic [TICK_W-1:0]   elapsed_q;
  logic [TICK_W-1:0]   elapsed_inc;
  logic [TICK_W-1:0]   elapsed_d;
  logic [LEVEL_W-1:0]  level_q;
  logic [LEVEL_W-1:0]  level_next;
  logic [LEVEL_W-1:0]  level_d;
  logic                upd;

  // pattern arithmetic
  logic [LEVEL_W-1:0]    noise_span;
  logic [2*LEVEL_W-1:0]  noise_prod;
  logic [LEVEL_W:0]      ramp_up_sum;
  logic [LEVEL_W-1:0]    ramp_down_dif;

  // ---------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_OFF;
      range_min_q   <= '0;
      range_max_q   <= LEVEL_TOP;
      sleep_q       <= SLEEP_RESET;
      red_ratio_q   <= RATIO_ONE;
      green_ratio_q <= RATIO_ONE;
      blue_ratio_q  <= RATIO_ONE;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PATTERN_MODE: mode_q        <= cfg_data_i[MODE_W-1:0];
        REG_RANGE_MIN:    range_min_q   <= cfg_data_i[LEVEL_W-1:0];
        REG_RANGE_MAX:    range_max_q   <= cfg_data_i[LEVEL_W-1:0];
        REG_SLEEP_MS:     sleep_q       <= cfg_data_i[SLEEP_W-1:0];
        REG_RED_RATIO:    red_ratio_q   <= cfg_data_i[RATIO_W-1:0];
        REG_GREEN_RATIO:  green_ratio_q <= cfg_data_i[RATIO_W-1:0];
        REG_BLUE_RATIO:   blue_ratio_q  <= cfg_data_i[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: the pipe moves unless a result sits unread at the output
  // ---------------------------------------------------------------------
  assign advance        = !c_valid_q || item_out.ready;
  assign item_in.ready  = advance;

  // ---------------------------------------------------------------------
  // Stage B logic: tick count and next level
  // ---------------------------------------------------------------------
  assign noise_span    = range_max_q - range_min_q;
  assign noise_prod    = {{LEVEL_W{1'b0}}, a_rnd_q} * {{SAMPLE_W{1'b0}}, noise_span};
  assign ramp_up_sum   = {1'b0, level_q} + {{LEVEL_W{1'b0}}, 1'b1};
  assign ramp_down_dif = level_q - {{(LEVEL_W-1){1'b0}}, 1'b1};

  always_comb begin
    case (mode_e'(mode_q))
      MODE_OFF:     level_next = '0;
      MODE_ON:      level_next = range_max_q;
      MODE_NOISE: begin
        // an empty or inverted range pins the level at the minimum
        if (range_max_q <= range_min_q) level_next = range_min_q;
        else level_next = range_min_q + noise_prod[2*LEVEL_W-1:LEVEL_W];
      end
      MODE_FLICKER: level_next = a_rnd_q[0] ? range_max_q : '0;
      MODE_FLASH:   level_next = (level_q == range_max_q) ? range_min_q : range_max_q;
      MODE_RAMP_UP: begin
        // compare before the 8-bit wrap so 255 + 1 goes back to the minimum
        if (ramp_up_sum > {1'b0, range_max_q}) level_next = range_min_q;
        else level_next = ramp_up_sum[LEVEL_W-1:0];
      end
      MODE_RAMP_DOWN: begin
        if (level_q == '0 || ramp_down_dif < range_min_q) level_next = range_max_q;
        else level_next = ramp_down_dif;
      end
      default:      level_next = level_q;  // unused code keeps the level
    endcase
  end

  always_comb begin
    elapsed_inc = (elapsed_q < TICK_MAX) ? elapsed_q + {{(TICK_W-1){1'b0}}, 1'b1}
                                         : elapsed_q;
    upd         = elapsed_inc > {1'b0, sleep_q};
    elapsed_d   = upd ? '0 : elapsed_inc;
    level_d     = upd ? level_next : level_q;
  end

  // ---------------------------------------------------------------------
  // Color scaling for stage C: (level * ratio) >> 8, saturated
  // ---------------------------------------------------------------------
  function automatic logic [LEVEL_W-1:0] scale_sat(input logic [LEVEL_W-1:0] lvl,
                                                   input logic [RATIO_W-1:0] ratio);
    logic [LEVEL_W+RATIO_W-1:0] prod;
    prod = {{RATIO_W{1'b0}}, lvl} * {{LEVEL_W{1'b0}}, ratio};
    return prod[LEVEL_W+RATIO_W-1] ? LEVEL_TOP : prod[LEVEL_W+RATIO_W-2:LEVEL_W];
  endfunction

  // ---------------------------------------------------------------------
  // Pipeline and state registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      elapsed_q <= '0;
      level_q   <= LEVEL_RESET;
      red_q     <= '0;
      green_q   <= '0;
      blue_q    <= '0;
    end else if (advance) begin
      a_valid_q <= item_in.valid;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      if (a_valid_q) begin
        elapsed_q <= elapsed_d;
        level_q   <= level_d;
      end
      // drives are state too: they move only on an update tick
      if (b_valid_q && b_upd_q) begin
        red_q   <= scale_sat(b_level_q, red_ratio_q);
        green_q <= scale_sat(b_level_q, green_ratio_q);
        blue_q  <= scale_sat(b_level_q, blue_ratio_q);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (item_in.valid) a_rnd_q <= item_in.random_sample;
      if (a_valid_q) begin
        b_upd_q   <= upd;
        b_level_q <= level_d;
      end
      if (b_valid_q) begin
        c_upd_q   <= b_upd_q;
        c_level_q <= b_level_q;
      end
    end
  end

  assign item_out.valid       = c_valid_q;
  assign item_out.red_drive   = red_q;
  assign item_out.green_drive = green_q;
  assign item_out.blue_drive  = blue_q;
  assign item_out.level_now   = c_level_q;
  assign item_out.updated     = c_upd_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // the largest sleep forces an update at 65536, so the count never goes past it
  a_tick_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    elapsed_q <= 17'h10000)
    else $error("tick counter ran past the largest sleep");

  // input only stalls behind an unread result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_in.ready |-> (item_out.valid && !item_out.ready))
    else $error("input stalled without output backpressure");

  // off mode always drives the level to zero on an update
  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_out.valid && item_out.updated && mode_q == MODE_OFF) |-> item_out.level_now == '0)
    else $error("off mode update left a nonzero level");

  // unity ratio passes the updated level straight to the red drive
  a_unity_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_out.valid && item_out.updated && red_ratio_q == RATIO_ONE)
      |-> item_out.red_drive == item_out.level_now)
    else $error("red drive does not match level at unity ratio");

endmodule

`default_nettype wire

FILE: tb/rgblpg_checker.sv
// Scoreboard for the RGB light pattern generator: tracks register writes,
// predicts one light result per accepted tick and compares in order.
// Depends on rgblpg_pkg and rgblpg_if.
`default_nettype none

module rgblpg_checker (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [rgblpg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [rgblpg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  rgblpg_in_if                             tick_mon,
  rgblpg_out_if                            light_mon,
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o,
  output int unsigned                      lights_seen_o,
  output int unsigned                      updates_seen_o
);
  import rgblpg_pkg::*;

  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic [LEVEL_W-1:0] level;
    logic               updated;
  } light_t;

  // shadow of the register file
  logic [MODE_W-1:0]  mode_q;
  logic [LEVEL_W-1:0] lo_q;
  logic [LEVEL_W-1:0] hi_q;
  logic [SLEEP_W-1:0] sleep_q;
  logic [RATIO_W-1:0] ratio_q [3];

  // shadow of the pattern state
  logic [TICK_W-1:0]  ticks_q;
  logic [LEVEL_W-1:0] level_q;
  logic [LEVEL_W-1:0] drive_q [3];

  light_t             light_expect_q [$];
  int unsigned        reported;

  function automatic logic [LEVEL_W-1:0] pattern_level(input logic [LEVEL_W-1:0]  cur,
                                                       input logic [SAMPLE_W-1:0] rnd);
    logic [15:0] span;
    case (mode_q)
      MODE_OFF:     return '0;
      MODE_ON:      return hi_q;
      MODE_NOISE: begin
        if (hi_q <= lo_q) return lo_q;
        span = {8'd0, rnd} * ({8'd0, hi_q} - {8'd0, lo_q});
        return lo_q + span[15:8];
      end
      MODE_FLICKER: return rnd[0] ? hi_q : '0;
      MODE_FLASH:   return (cur == hi_q) ? lo_q : hi_q;
      MODE_RAMP_UP: return ({1'b0, cur} + 9'd1 > {1'b0, hi_q}) ? lo_q : cur + 8'd1;
      MODE_RAMP_DOWN: begin
        if (cur == '0 || cur - 8'd1 < lo_q) return hi_q;
        return cur - 8'd1;
      end
      default:      return cur;  // spare code keeps the level
    endcase
  endfunction

  function automatic logic [LEVEL_W-1:0] scaled(input logic [LEVEL_W-1:0] level,
                                                input logic [RATIO_W-1:0] ratio);
    logic [16:0] prod;
    prod = {9'd0, level} * {8'd0, ratio};
    return (prod[16:8] > 9'd255) ? LEVEL_TOP : prod[15:8];
  endfunction

  // advances the shadow state by one tick and returns the light it shows
  function automatic light_t advance_tick(input logic [SAMPLE_W-1:0] rnd);
    light_t l;
    l.updated = 1'b0;
    if (ticks_q < TICK_MAX) ticks_q = ticks_q + 1'b1;
    if (ticks_q > {1'b0, sleep_q}) begin
      level_q = pattern_level(level_q, rnd);
      for (int c = 0; c < 3; c++) drive_q[c] = scaled(level_q, ratio_q[c]);
      ticks_q   = '0;
      l.updated = 1'b1;
    end
    l.red   = drive_q[0];
    l.green = drive_q[1];
    l.blue  = drive_q[2];
    l.level = level_q;
    return l;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    light_t want;
    light_t got;
    if (!rst_ni) begin
      mode_q   = MODE_OFF;
      lo_q     = '0;
      hi_q     = LEVEL_TOP;
      sleep_q  = SLEEP_RESET;
      for (int c = 0; c < 3; c++) begin
        ratio_q[c] = RATIO_ONE;
        drive_q[c] = '0;
      end
      ticks_q  = '0;
      level_q  = LEVEL_RESET;
      light_expect_q.delete();
      reported       = 0;
      fail_count_o   = 0;
      pending_o      = 0;
      lights_seen_o  = 0;
      updates_seen_o = 0;
    end else begin
      if (light_mon.valid && light_mon.ready) begin
        got = '{light_mon.red_drive, light_mon.green_drive, light_mon.blue_drive,
                light_mon.level_now, light_mon.updated};
        lights_seen_o++;
        if (got.updated) updates_seen_o++;
        if (light_expect_q.size() == 0) begin
          fail_count_o++;
          if (reported < REPORT_MAX) begin
            reported++;
            $display("[%0t] unexpected light item r=%h g=%h b=%h lvl=%h upd=%b", $realtime,
                     got.red, got.green, got.blue, got.level, got.updated);
          end
        end else begin
          want = light_expect_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (reported < REPORT_MAX) begin
              reported++;
              $display("[%0t] light mismatch: exp r=%h g=%h b=%h lvl=%h upd=%b", $realtime,
                       want.red, want.green, want.blue, want.level, want.updated);
              $display("[%0t]                 got r=%h g=%h b=%h lvl=%h upd=%b", $realtime,
                       got.red, got.green, got.blue, got.level, got.updated);
            end
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PATTERN_MODE: mode_q     = cfg_data_i[MODE_W-1:0];
          REG_RANGE_MIN:    lo_q       = cfg_data_i[LEVEL_W-1:0];
          REG_RANGE_MAX:    hi_q       = cfg_data_i[LEVEL_W-1:0];
          REG_SLEEP_MS:     sleep_q    = cfg_data_i[SLEEP_W-1:0];
          REG_RED_RATIO:    ratio_q[0] = cfg_data_i[RATIO_W-1:0];
          REG_GREEN_RATIO:  ratio_q[1] = cfg_data_i[RATIO_W-1:0];
          REG_BLUE_RATIO:   ratio_q[2] = cfg_data_i[RATIO_W-1:0];
          default: ;
        endcase
      end

      if (tick_mon.valid && tick_mon.ready) begin
        light_expect_q.push_back(advance_tick(tick_mon.random_sample));
      end
      pending_o = light_expect_q.size();
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb_rgb_light_pattern_generator_unit.sv
// Testbench top for rgb_light_pattern_generator_unit: clock, reset, tick
// stimulus, register settings, random back-pressure and the verdict.
// Depends on rgblpg_pkg, rgblpg_if, rgblpg_checker and the block itself.
`default_nettype none

module tb_rgb_light_pattern_generator_unit;
  import rgblpg_pkg::*;

  localparam logic [MODE_W-1:0]    MODE_SPARE  = 3'd7;  // unused mode code
  localparam logic [CFG_IDX_W-1:0] REG_NONE    = 3'd7;  // no register here
  localparam int unsigned          PIPE_SETTLE = 4;     // 3-stage pipe plus margin
  localparam int unsigned          HOLD_CYCLES = 200;   // long result stall
  localparam int unsigned          TICK_GOAL   = 530;   // directed + ~500 random
  localparam int unsigned          CYCLE_LIMIT = 400000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rgblpg_in_if  tick_ch ();
  rgblpg_out_if light_ch ();

  int unsigned fail_count;
  int unsigned light_pending;
  int unsigned lights_seen;
  int unsigned updates_seen;
  int unsigned ticks_sent;
  int unsigned settings_loaded;
  int unsigned cycle_count;

  // steady: no gaps on either side; hold_off: sink stalls for HOLD_CYCLES
  bit steady;
  bit hold_off;

  rgb_light_pattern_generator_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_in    (tick_ch),
    .item_out   (light_ch)
  );

  rgblpg_checker chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .tick_mon       (tick_ch),
    .light_mon      (light_ch),
    .fail_count_o   (fail_count),
    .pending_o      (light_pending),
    .lights_seen_o  (lights_seen),
    .updates_seen_o (updates_seen)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Watchdog: a hung handshake or lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d light items still owed", cycle_count,
               light_pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return LEVEL_TOP;
    return $urandom_range(0, 255);
  endfunction

  function automatic logic [RATIO_W-1:0] pick_ratio();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 35) return RATIO_ONE;
    if (r < 50) return 9'd511;
    return $urandom_range(0, 511);
  endfunction

  // Short sleeps keep updates frequent; the top value checks the long count.
  function automatic logic [SLEEP_W-1:0] pick_sleep();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return '0;
    if (r < 75) return $urandom_range(1, 4);
    if (r < 94) return $urandom_range(5, 40);
    return 16'hFFFF;
  endfunction

  // Result sink. Each negedge decides ready for the next cycle; a hold-off
  // request from the stimulus freezes it long enough to back the pipe up.
  initial begin : light_sink
    int stall_left;
    light_ch.ready = 1'b0;
    stall_left     = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        light_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off = 1'b0;
      end else if (stall_left > 0) begin
        light_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        light_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // One register write; called and returning at a negedge. Write enable is
  // left high so back-to-back writes need no extra edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
  endtask

  // Sender pauses until every owed light item is out, lets the pipe settle,
  // then rewrites all registers. Unused data bits carry random junk that the
  // block must mask; a write to the empty index must be ignored.
  task automatic load_setting(input logic [MODE_W-1:0]  mode,
                              input logic [LEVEL_W-1:0] lo,
                              input logic [LEVEL_W-1:0] hi,
                              input logic [SLEEP_W-1:0] sleep,
                              input logic [RATIO_W-1:0] red,
                              input logic [RATIO_W-1:0] green,
                              input logic [RATIO_W-1:0] blue);
    logic [CFG_DATA_W-1:0] word;
    tick_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (light_pending != 0) @(negedge clk_i);
    repeat (PIPE_SETTLE) @(negedge clk_i);
    word = $urandom; word[MODE_W-1:0]  = mode;  write_reg(REG_PATTERN_MODE, word);
    word = $urandom; word[LEVEL_W-1:0] = lo;    write_reg(REG_RANGE_MIN, word);
    word = $urandom; word[LEVEL_W-1:0] = hi;    write_reg(REG_RANGE_MAX, word);
    word = sleep;                               write_reg(REG_SLEEP_MS, word);
    word = $urandom; word[RATIO_W-1:0] = red;   write_reg(REG_RED_RATIO, word);
    word = $urandom; word[RATIO_W-1:0] = green; write_reg(REG_GREEN_RATIO, word);
    word = $urandom; word[RATIO_W-1:0] = blue;  write_reg(REG_BLUE_RATIO, word);
    word = $urandom;                            write_reg(REG_NONE, word);
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  // Offer one tick item, optionally after a gap; returns at the negedge after
  // acceptance with valid still high so the next item can follow directly.
  task automatic send_tick(input logic [SAMPLE_W-1:0] sample);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tick_ch.valid         <= 1'b1;
    tick_ch.random_sample <= sample;
    @(posedge clk_i);
    while (!tick_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    ticks_sent++;
  endtask

  task automatic send_random_ticks(input int n);
    repeat (n) send_tick($urandom);
  endtask

  initial begin : stimulus
    logic [MODE_W-1:0]  mode;
    logic [LEVEL_W-1:0] lo;
    logic [LEVEL_W-1:0] hi;
    logic [LEVEL_W-1:0] swap;
    logic [SLEEP_W-1:0] sleep;
    int                 burst;
    int                 n;

    // every block input known from time zero
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = '0;
    cfg_data_i            = '0;
    tick_ch.valid         = 1'b0;
    tick_ch.random_sample = '0;
    steady                = 1'b0;
    hold_off              = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // --- directed part ---
    // Reset values: sleep 100, so nothing updates and drives stay at zero.
    send_tick(8'h00);
    send_tick(8'hFF);
    send_tick(8'h5A);

    // On at full range with a zero ratio and a ratio above 1.0 (saturates).
    load_setting(MODE_ON, 8'd0, 8'd255, 16'd0, 9'd256, 9'd0, 9'd511);
    send_tick(8'h00);
    send_tick(8'hFF);

    // Noise at both sample extremes, then with an inverted range.
    load_setting(MODE_NOISE, 8'd10, 8'd200, 16'd0, 9'd128, 9'd300, 9'd511);
    send_tick(8'h00);
    send_tick(8'hFF);
    load_setting(MODE_NOISE, 8'd200, 8'd100, 16'd0, 9'd256, 9'd256, 9'd256);
    send_tick(8'h80);

    // Flicker on the low sample bit, updating every second tick.
    load_setting(MODE_FLICKER, 8'd0, 8'd255, 16'd1, 9'd256, 9'd64, 9'd1);
    send_tick(8'h01);
    send_tick(8'hFE);
    send_tick(8'h01);
    send_tick(8'hFF);

    // Flash toggles between the range ends.
    load_setting(MODE_FLASH, 8'd5, 8'd250, 16'd0, 9'd256, 9'd256, 9'd256);
    send_random_ticks(3);

    // Ramp up through 255, where the increment wraps to the minimum.
    load_setting(MODE_RAMP_UP, 8'd253, 8'd255, 16'd0, 9'd511, 9'd256, 9'd0);
    send_random_ticks(7);

    // Off forces level 0; ramp down from there wraps to the maximum.
    load_setting(MODE_OFF, 8'd0, 8'd255, 16'd0, 9'd256, 9'd256, 9'd256);
    send_tick(8'hC3);
    load_setting(MODE_RAMP_DOWN, 8'd0, 8'd2, 16'd0, 9'd256, 9'd200, 9'd100);
    send_random_ticks(3);

    // Spare mode code: level holds, drives are still recomputed.
    load_setting(MODE_SPARE, 8'd0, 8'd255, 16'd0, 9'd17, 9'd511, 9'd256);
    send_random_ticks(2);

    // --- random part ---
    burst = 0;
    while (ticks_sent < TICK_GOAL) begin
      mode = $urandom_range(0, 7);
      lo   = pick_level();
      hi   = pick_level();
      // patterns do most with a proper range; keep some inverted ones
      if (lo > hi && $urandom_range(0, 9) < 7) begin
        swap = lo;
        lo   = hi;
        hi   = swap;
      end
      sleep = pick_sleep();
      load_setting(mode, lo, hi, sleep, pick_ratio(), pick_ratio(), pick_ratio());
      burst++;
      steady = ($urandom_range(0, 3) == 0);
      if (burst == 1) begin
        // sender keeps offering while the sink holds off, so the pipe
        // fills and the block has to refuse ticks
        steady   = 1'b1;
        hold_off = 1'b1;
      end
      n = (sleep == 16'hFFFF) ? $urandom_range(3, 10) : $urandom_range(8, 40);
      send_random_ticks(n);
      steady = 1'b0;
    end

    // --- drain and verdict ---
    tick_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (light_pending != 0) @(negedge clk_i);
    repeat (2 * PIPE_SETTLE) @(negedge clk_i);

    $display("Run covered %0d ticks under %0d register settings, all mode codes included.",
             ticks_sent, settings_loaded);
    $display("%0d light items checked, %0d with a pattern update; %0d failures.",
             lights_seen, updates_seen, fail_count + light_pending);
    if (fail_count == 0 && light_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
